// ===== rtl/core/psnr_pkg.sv =====
// ============================================================================
// psnr_pkg: shared constants and types of the PSNR metric engine
// Widths of the accumulators, the log and divide iteration constants, result
// kind codes and the structs that pass between the engine's units.
// ============================================================================
package psnr_pkg;

	// Defaults for the top-level parameters.
	localparam int SAMPLE_BITS_DEF    = 32;
	localparam int COUNT_BITS_DEF     = 32;
	localparam int PSNR_FRAC_BITS_DEF = 16;

	// Squared-error sum and its log.
	localparam int SUM_BITS   = 128;
	localparam int LOG_FRAC   = 28;
	localparam int LOG_ITER_W = 5;
	localparam int LOG_EXP_W  = 7;
	localparam int LOG_W      = LOG_EXP_W + LOG_FRAC;

	// Mean squared error: sum * 2^16 / count, bit by bit.
	localparam int MSE_WHOLE_BITS = 64;
	localparam int MSE_FRAC_BITS  = 16;
	localparam int QUO_BITS       = MSE_WHOLE_BITS + MSE_FRAC_BITS;
	localparam int DIV_STEPS      = SUM_BITS + MSE_FRAC_BITS;
	localparam int DIV_STEP_W     = 8;
	localparam int OVF_STEPS      = DIV_STEPS - QUO_BITS;

	// 10*log10(2) in Q2.30.
	localparam logic [31:0] TEN_LOG10_2_Q30 = 32'd3232284966;

	// PSNR output and its accumulation width.
	localparam int PSNR_W     = 26;
	localparam int PSNR_TOT_W = 70;
	localparam logic [PSNR_W-1:0] PSNR_MAX = {1'b0, {(PSNR_W-1){1'b1}}};

	// Result kind codes.
	localparam logic [1:0] KIND_FINITE  = 2'd0;
	localparam logic [1:0] KIND_POS_INF = 2'd1;
	localparam logic [1:0] KIND_NEG_INF = 2'd2;

	// Operands presented to the shared multiplier.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} mul_opnd_t;

	// Status and quotient of the divider.
	typedef struct packed {
		logic                      busy;
		logic [MSE_WHOLE_BITS-1:0] mse_whole;
		logic [MSE_FRAC_BITS-1:0]  mse_fraction;
	} div_res_t;

endpackage

// ===== rtl/core/psnr_in_if.sv =====
// ============================================================================
// psnr_in_if: sample pair channel
// Valid/ready channel carrying one reconstructed and one ground-truth sample.
// ============================================================================
interface psnr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] rec_sample;
	logic [31:0] truth_sample;
	logic        last_pair;

	modport source (output valid, rec_sample, truth_sample, last_pair, input ready);
	modport sink (input valid, rec_sample, truth_sample, last_pair, output ready);
endinterface

// ===== rtl/core/psnr_out_if.sv =====
// ============================================================================
// psnr_out_if: metric result channel
// Valid/ready channel carrying the count, MSE, range and PSNR of a data set.
// ============================================================================
interface psnr_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        pair_count;
	logic [63:0]        mse_whole;
	logic [15:0]        mse_fraction;
	logic [31:0]        truth_range;
	logic signed [25:0] psnr_db;
	logic [1:0]         psnr_kind;

	modport source (output valid, pair_count, mse_whole, mse_fraction, truth_range,
		psnr_db, psnr_kind, input ready);
	modport sink (input valid, pair_count, mse_whole, mse_fraction, truth_range,
		psnr_db, psnr_kind, output ready);
endinterface

// ===== rtl/core/psnr_mul.sv =====
// ============================================================================
// psnr_mul: shared 32x32 multiplier
// Unsigned product of the presented operands, held in an output register.
// ============================================================================
module psnr_mul (
	input  logic                  clk,
	input  psnr_pkg::mul_opnd_t   opnd,
	output logic [63:0]           prod
);
	import psnr_pkg::*;

	always_ff @(posedge clk) begin
		prod <= 64'(opnd.a) * 64'(opnd.b);
	end

endmodule

// ===== rtl/core/psnr_div.sv =====
// ============================================================================
// psnr_div: restoring divider for the mean squared error
// Forms floor(sum * 2^16 / count) one quotient bit per cycle and flags a
// quotient that does not fit the 64.16 result.
// ============================================================================
module psnr_div #(
	parameter int COUNT_BITS = psnr_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psnr_pkg::SUM_BITS-1:0] dividend,
	input  logic [COUNT_BITS-1:0]         divisor,
	output psnr_pkg::div_res_t            res
);
	import psnr_pkg::*;

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [SUM_BITS-1:0]   num_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [QUO_BITS-1:0]   quo_q;
	logic                  ovf_q;

	logic [COUNT_BITS:0]   rem_sh;
	logic [COUNT_BITS+1:0] diff;
	logic                  fits;

	// Bring down the next dividend bit and try the subtraction.
	assign rem_sh = {rem_q, num_q[SUM_BITS-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign fits   = ~diff[COUNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[SUM_BITS-2:0], 1'b0};
			rem_q  <= fits ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
			step_q <= step_q + DIV_STEP_W'(1);
			// The leading quotient bits lie above the 64.16 result.
			if (step_q < DIV_STEP_W'(OVF_STEPS)) begin
				ovf_q <= ovf_q | fits;
			end else begin
				quo_q <= {quo_q[QUO_BITS-2:0], fits};
			end
		end
	end

	assign res.busy         = busy_q;
	assign res.mse_whole    = ovf_q ? '1 : quo_q[QUO_BITS-1:MSE_FRAC_BITS];
	assign res.mse_fraction = ovf_q ? '1 : quo_q[MSE_FRAC_BITS-1:0];

endmodule

// ===== rtl/core/psnr_log2.sv =====
// ============================================================================
// psnr_log2: iterative base-2 logarithm
// Normalizes a nonzero 128-bit value in seven shift steps, then squares the
// 32-bit mantissa on the shared multiplier to produce the fraction bits.
// ============================================================================
module psnr_log2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psnr_pkg::SUM_BITS-1:0] value,
	input  logic [63:0]                   mul_prod,
	output psnr_pkg::mul_opnd_t           opnd,
	output logic                          done,
	output logic [psnr_pkg::LOG_W-1:0]    result
);
	import psnr_pkg::*;

	typedef enum logic [1:0] {
		L_IDLE,
		L_NORM,
		L_MUL,
		L_SQ
	} log_state_t;

	localparam logic [2:0] NORM_LAST = 3'd6;

	log_state_t            state_q;
	logic [SUM_BITS-1:0]   x_q;
	logic [LOG_EXP_W-1:0]  e_q;
	logic [2:0]            step_q;
	logic [LOG_ITER_W-1:0] iter_q;
	logic [LOG_FRAC-1:0]   frac_q;
	logic                  done_q;
	logic [LOG_W-1:0]      result_q;

	logic [7:0]            sh;
	logic                  top_zero;
	logic [31:0]           sq_m;
	logic [LOG_FRAC-1:0]   frac_nxt;
	logic                  last_sq;

	// Normalization step: shift by 64, 32, ... 1 when that many top bits are zero.
	assign sh       = 8'd64 >> step_q;
	assign top_zero = (x_q >> (8'd128 - sh)) == '0;

	// The square lies in [1,4); renormalize and emit one fraction bit.
	assign sq_m     = mul_prod[63] ? mul_prod[63:32] : mul_prod[62:31];
	assign frac_nxt = {frac_q[LOG_FRAC-2:0], mul_prod[63]};

	// The final squaring produces the last fraction bit.
	assign last_sq  = (state_q == L_SQ) && (iter_q == LOG_ITER_W'(LOG_FRAC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= last_sq;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						x_q     <= value;
						e_q     <= LOG_EXP_W'(SUM_BITS - 1);
						step_q  <= '0;
						iter_q  <= '0;
						frac_q  <= '0;
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (top_zero) begin
						x_q <= x_q << sh;
						e_q <= e_q - sh[LOG_EXP_W-1:0];
					end
					step_q <= step_q + 3'd1;
					if (step_q == NORM_LAST) begin
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					state_q <= L_SQ;
				end
				L_SQ: begin
					x_q[SUM_BITS-1 -: 32] <= sq_m;
					frac_q <= frac_nxt;
					iter_q <= iter_q + LOG_ITER_W'(1);
					if (last_sq) begin
						result_q <= {e_q, frac_nxt};
						state_q  <= L_IDLE;
					end else begin
						state_q <= L_MUL;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign opnd.a = x_q[SUM_BITS-1 -: 32];
	assign opnd.b = x_q[SUM_BITS-1 -: 32];
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/psnr_metric_engine.sv =====
// ============================================================================
// psnr_metric_engine: peak signal-to-noise ratio over a stream of sample pairs
// Accumulates squared error, ground-truth extremes and a pair count, and on
// the closing item reports count, MSE, range and PSNR in fixed point.
// ============================================================================
// Each accepted item carries one reconstructed and one ground-truth sample in
// the integer format held in the sample format register (written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the engine is
// idle, as the block itself does not enforce this). An ordinary item passes
// through accept, difference, square on the shared 32x32 multiplier, and a
// 128-bit accumulate; ready is low for all but the accept. The item marked
// last_pair then starts the closing sequence: the mean squared error comes
// from a restoring divider that produces one quotient bit per cycle, and in
// parallel the three base-2 logarithms (range, count and sum) run one after
// another, each with 7 normalization steps and then 28 mantissa squarings
// that share the same multiplier. A closing item whose PSNR is infinite
// skips the logarithms and waits only for the divider. The result sits in an
// output register, so the next data set may begin while the result waits
// to be taken. The accumulators return to their reset values once a result
// has been loaded. PSNR is reported in units of 2^-PSNR_FRAC_BITS dB,
// saturating at the output width, and psnr_kind marks a zero squared-error
// sum (plus infinity) ahead of a zero range (minus infinity); psnr_db reads
// zero for either of those.
module psnr_metric_engine #(
	parameter int SAMPLE_BITS    = psnr_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS     = psnr_pkg::COUNT_BITS_DEF,
	parameter int PSNR_FRAC_BITS = psnr_pkg::PSNR_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_wr_data,
	psnr_in_if.sink           pairs,
	psnr_out_if.source        result
);
	import psnr_pkg::*;

	// Sample format codes; the unused codes decode as u32.
	localparam logic [2:0] FMT_I8  = 3'd0;
	localparam logic [2:0] FMT_U8  = 3'd1;
	localparam logic [2:0] FMT_I16 = 3'd2;
	localparam logic [2:0] FMT_U16 = 3'd3;
	localparam logic [2:0] FMT_I32 = 3'd4;
	localparam logic [2:0] FMT_RESET = FMT_U16;

	localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);

	// PSNR scaling: the log sum has LOG_FRAC fraction bits, the constant 30.
	localparam int PSNR_SHIFT = LOG_FRAC + 30 - PSNR_FRAC_BITS;
	localparam logic [PSNR_TOT_W-1:0] PSNR_RND = PSNR_TOT_W'(1) << (PSNR_SHIFT - 1);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIFF,
		S_SQ,
		S_ACC,
		S_RANGE,
		S_START,
		S_LOG_RNG,
		S_LOG_CNT,
		S_LOG_SUM,
		S_ABS,
		S_PMUL_LO,
		S_PMUL_HI,
		S_PSUM,
		S_PSAT,
		S_WAIT_DIV,
		S_OUT
	} eng_state_t;

	// Sign-extends or zero-extends the raw bits to a common 33-bit signed value.
	function automatic logic [32:0] decode_sample(input logic [31:0] raw,
		input logic [2:0] fmt);
		logic [31:0] v;
		v = raw & SAMPLE_MASK;
		unique case (fmt)
			FMT_I8:  return {{25{v[7]}}, v[7:0]};
			FMT_U8:  return {25'b0, v[7:0]};
			FMT_I16: return {{17{v[15]}}, v[15:0]};
			FMT_U16: return {17'b0, v[15:0]};
			FMT_I32: return {v[31], v};
			default: return {1'b0, v};
		endcase
	endfunction

	eng_state_t                 state_q;
	logic [2:0]                 fmt_q;

	// Data-set accumulators.
	logic [SUM_BITS-1:0]        sum_q;
	logic [COUNT_BITS-1:0]      cnt_q;
	logic signed [32:0]         min_q;
	logic signed [32:0]         max_q;

	// Per-item working registers.
	logic signed [32:0]         rec_q;
	logic signed [32:0]         tru_q;
	logic                       last_q;
	logic [31:0]                ad_q;

	// Closing sequence registers.
	logic [31:0]                rng_q;
	logic [1:0]                 kind_q;
	logic [LOG_W-1:0]           lr_q;
	logic [LOG_W-1:0]           lc_q;
	logic [LOG_W+2:0]           l_q;
	logic [LOG_W+1:0]           a_q;
	logic                       neg_q;
	logic [63:0]                plo_q;
	logic [PSNR_TOT_W-1:0]      total_q;
	logic [PSNR_W-1:0]          psnr_q;

	// Output register.
	logic                       out_valid_q;
	logic [31:0]                out_count_q;
	logic [MSE_WHOLE_BITS-1:0]  out_whole_q;
	logic [MSE_FRAC_BITS-1:0]   out_frac_q;
	logic [31:0]                out_range_q;
	logic [PSNR_W-1:0]          out_psnr_q;
	logic [1:0]                 out_kind_q;

	// Combinational helpers.
	logic [33:0]                diff;
	logic [33:0]                diff_neg;
	logic [33:0]                rng_diff;
	logic [LOG_W+2:0]           l_neg;
	logic [PSNR_TOT_W-1:0]      mag_full;
	logic [PSNR_W-1:0]          mag;
	logic [63:0]                cnt_wide;
	logic [31:0]                cnt_sat;
	logic                       sum_zero;
	logic                       out_load;

	// Shared units.
	mul_opnd_t                  mul_opnd;
	mul_opnd_t                  log_opnd;
	logic [63:0]                mul_p;
	logic                       log_start;
	logic [SUM_BITS-1:0]        log_val;
	logic                       log_done;
	logic [LOG_W-1:0]           log_res;
	logic                       div_start;
	div_res_t                   div_res;

	assign diff     = {rec_q[32], rec_q} - {tru_q[32], tru_q};
	assign diff_neg = 34'd0 - diff;
	assign rng_diff = {max_q[32], max_q} - {min_q[32], min_q};
	assign l_neg    = '0 - l_q;
	assign mag_full = total_q >> PSNR_SHIFT;
	assign mag      = (mag_full > PSNR_TOT_W'(PSNR_MAX)) ? PSNR_MAX : mag_full[PSNR_W-1:0];
	assign cnt_wide = 64'(cnt_q);
	assign cnt_sat  = (cnt_wide > 64'h0000_0000_FFFF_FFFF) ? '1 : cnt_wide[31:0];
	assign sum_zero = (sum_q == '0);

	// A finished report enters the output register when it is empty or being
	// emptied in the same cycle.
	assign out_load = (state_q == S_OUT) && (!out_valid_q || result.ready);

	// The multiplier squares the difference and scales the log sum; the log
	// unit owns it at every other time.
	always_comb begin
		mul_opnd = log_opnd;
		case (state_q)
			S_SQ: begin
				mul_opnd.a = ad_q;
				mul_opnd.b = ad_q;
			end
			S_PMUL_LO: begin
				mul_opnd.a = a_q[31:0];
				mul_opnd.b = TEN_LOG10_2_Q30;
			end
			S_PMUL_HI: begin
				mul_opnd.a = 32'(a_q[LOG_W+1:32]);
				mul_opnd.b = TEN_LOG10_2_Q30;
			end
			default: mul_opnd = log_opnd;
		endcase
	end

	// The three logarithms run back to back: range, count, then sum.
	assign log_start = (state_q == S_START && !sum_zero && rng_q != '0)
		|| (state_q == S_LOG_RNG && log_done)
		|| (state_q == S_LOG_CNT && log_done);

	always_comb begin
		case (state_q)
			S_LOG_RNG: log_val = SUM_BITS'(cnt_q);
			S_LOG_CNT: log_val = sum_q;
			default:   log_val = SUM_BITS'(rng_q);
		endcase
	end

	assign div_start = (state_q == S_START);

	psnr_mul u_mul (
		.clk  (clk),
		.opnd (mul_opnd),
		.prod (mul_p)
	);

	psnr_log2 u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (log_start),
		.value    (log_val),
		.mul_prod (mul_p),
		.opnd     (log_opnd),
		.done     (log_done),
		.result   (log_res)
	);

	psnr_div #(
		.COUNT_BITS (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fmt_q       <= FMT_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fmt_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pairs.valid) begin
						rec_q   <= decode_sample(pairs.rec_sample, fmt_q);
						tru_q   <= decode_sample(pairs.truth_sample, fmt_q);
						last_q  <= pairs.last_pair;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					ad_q <= diff[33] ? diff_neg[31:0] : diff[31:0];
					if (cnt_q == '0) begin
						min_q <= tru_q;
						max_q <= tru_q;
					end else begin
						if (tru_q < min_q) begin
							min_q <= tru_q;
						end
						if (tru_q > max_q) begin
							max_q <= tru_q;
						end
					end
					// The count holds once it reaches its maximum.
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + COUNT_BITS'(1);
					end
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					sum_q   <= sum_q + SUM_BITS'(mul_p);
					state_q <= last_q ? S_RANGE : S_IDLE;
				end
				S_RANGE: begin
					// A format change inside a set can push the range past 32 bits.
					rng_q   <= (rng_diff[33:32] != 2'b00) ? '1 : rng_diff[31:0];
					state_q <= S_START;
				end
				S_START: begin
					psnr_q <= '0;
					if (sum_zero) begin
						kind_q  <= KIND_POS_INF;
						state_q <= S_WAIT_DIV;
					end else if (rng_q == '0) begin
						kind_q  <= KIND_NEG_INF;
						state_q <= S_WAIT_DIV;
					end else begin
						kind_q  <= KIND_FINITE;
						state_q <= S_LOG_RNG;
					end
				end
				S_LOG_RNG: begin
					if (log_done) begin
						lr_q    <= log_res;
						state_q <= S_LOG_CNT;
					end
				end
				S_LOG_CNT: begin
					if (log_done) begin
						lc_q    <= log_res;
						state_q <= S_LOG_SUM;
					end
				end
				S_LOG_SUM: begin
					// 2*log2(range) + log2(count) - log2(sum), two's complement.
					if (log_done) begin
						l_q <= {2'b00, lr_q, 1'b0} + {3'b000, lc_q} - {3'b000, log_res};
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					a_q     <= l_q[LOG_W+2] ? l_neg[LOG_W+1:0] : l_q[LOG_W+1:0];
					neg_q   <= l_q[LOG_W+2];
					state_q <= S_PMUL_LO;
				end
				S_PMUL_LO: begin
					state_q <= S_PMUL_HI;
				end
				S_PMUL_HI: begin
					plo_q   <= mul_p;
					state_q <= S_PSUM;
				end
				S_PSUM: begin
					// Upper partial product weighs 2^32; add half an LSB to round.
					total_q <= (PSNR_TOT_W'(mul_p) << 32) + PSNR_TOT_W'(plo_q) + PSNR_RND;
					state_q <= S_PSAT;
				end
				S_PSAT: begin
					psnr_q  <= neg_q ? (PSNR_W'(0) - mag) : mag;
					state_q <= S_WAIT_DIV;
				end
				S_WAIT_DIV: begin
					if (!div_res.busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_count_q <= cnt_sat;
						out_whole_q <= div_res.mse_whole;
						out_frac_q  <= div_res.mse_fraction;
						out_range_q <= rng_q;
						out_psnr_q  <= psnr_q;
						out_kind_q  <= kind_q;
						sum_q       <= '0;
						cnt_q       <= '0;
						min_q       <= '0;
						max_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pairs.ready = (state_q == S_IDLE);

	assign result.valid        = out_valid_q;
	assign result.pair_count   = out_count_q;
	assign result.mse_whole    = out_whole_q;
	assign result.mse_fraction = out_frac_q;
	assign result.truth_range  = out_range_q;
	assign result.psnr_db      = out_psnr_q;
	assign result.psnr_kind    = out_kind_q;

endmodule
